/* sv/host_command_deframer_macros.svh */
// Assertion macros used by the host command deframer datapath.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef HOST_COMMAND_DEFRAMER_MACROS_SVH
`define HOST_COMMAND_DEFRAMER_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted
`define HCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted
`define HCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/hcd_pkg.sv */
// Shared constants and controller/datapath interface types for the deframer.
// No dependencies.
`default_nettype none

package hcd_pkg;

    // Packet store geometry
    localparam int PACKET_BYTES = 64;
    localparam int ADDR_W       = $clog2(PACKET_BYTES);
    localparam int CNT_W        = $clog2(PACKET_BYTES + 1);

    // Frame markers and fixed framing bytes
    localparam logic [7:0] START_MARK     = 8'h7E;
    localparam logic [7:0] STOP_MARK      = 8'h21;
    localparam int         FRAME_OVERHEAD = 5;

    // Robot limit and configuration register width
    localparam int RC_W       = 5;
    localparam int MAX_ROBOTS = 16;

    // Output field widths
    localparam int RID_W  = 4;
    localparam int SIZE_W = 6;

    // Configuration register indexes
    localparam int              CFG_IDX_W         = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_TYPE = 2'd1;

    // Read address select for the packet store
    typedef enum logic [2:0] {
        RD_HEAD,
        RD_TYPE,
        RD_RID,
        RD_SIZE,
        RD_STOP,
        RD_DATA,
        RD_DATA_NEXT
    } rd_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    accept;
        rd_sel_t rd_sel;
        logic    cap_type;
        logic    cap_rid;
        logic    cap_size;
        logic    pos_inc;
        logic    pos_skip;
        logic    idx_inc;
        logic    emit_note;
        logic    emit_data;
        logic    flush;
        logic    clear_fill;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic short_tail;
        logic head_ok;
        logic overrun;
        logic frame_ok;
        logic data_frame;
        logic last_data;
        logic emit_ok;
        logic flush_ok;
    } status_t;

endpackage

`default_nettype wire

/* sv/hcd_ctrl.sv */
// Scan sequencer for the deframer: loads bytes, then walks the stored packet.
// Depends on hcd_pkg for command and status types.
`default_nettype none

module hcd_ctrl
    import hcd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    packet_end,
    input  wire status_t status,
    output cmd_t         cmd,
    output logic         in_stall
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_HUNT,
        S_HEAD,
        S_TYPE,
        S_RID,
        S_SIZE,
        S_STOP,
        S_NOTE,
        S_DATA,
        S_FLUSH
    } state_t;

    state_t state_reg, state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_LOAD);

    // Decode state and status into datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_HEAD;
        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (packet_end)
                    begin
                        state_next = S_HUNT;
                    end
                end
            end
            S_HUNT:
            begin
                if (status.short_tail)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.rd_sel = RD_HEAD;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (!status.head_ok)
                begin
                    cmd.pos_inc = 1'b1;
                    state_next  = S_HUNT;
                end
                else
                begin
                    cmd.rd_sel = RD_TYPE;
                    state_next = S_TYPE;
                end
            end
            S_TYPE:
            begin
                cmd.cap_type = 1'b1;
                cmd.rd_sel   = RD_RID;
                state_next   = S_RID;
            end
            S_RID:
            begin
                cmd.cap_rid = 1'b1;
                cmd.rd_sel  = RD_SIZE;
                state_next  = S_SIZE;
            end
            S_SIZE:
            begin
                if (status.overrun)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cmd.cap_size = 1'b1;
                    cmd.rd_sel   = RD_STOP;
                    state_next   = S_STOP;
                end
            end
            S_STOP:
            begin
                if (!status.frame_ok)
                begin
                    cmd.pos_inc = 1'b1;
                    state_next  = S_HUNT;
                end
                else if (status.data_frame)
                begin
                    cmd.rd_sel = RD_DATA;
                    state_next = S_DATA;
                end
                else
                begin
                    state_next = S_NOTE;
                end
            end
            S_NOTE:
            begin
                if (status.emit_ok)
                begin
                    cmd.emit_note = 1'b1;
                    cmd.pos_skip  = 1'b1;
                    state_next    = S_HUNT;
                end
            end
            S_DATA:
            begin
                if (status.emit_ok)
                begin
                    cmd.emit_data = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    cmd.rd_sel    = RD_DATA_NEXT;
                    if (status.last_data)
                    begin
                        cmd.pos_skip = 1'b1;
                        state_next   = S_HUNT;
                    end
                end
                else
                begin
                    // keep the current payload byte in the read register
                    cmd.rd_sel = RD_DATA;
                end
            end
            S_FLUSH:
            begin
                cmd.flush = 1'b1;
                if (status.flush_ok)
                begin
                    cmd.clear_fill = 1'b1;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/hcd_datapath.sv */
// Packet store, scan counters, frame field registers and result staging.
// Depends on hcd_pkg and host_command_deframer_macros.svh.
`default_nettype none
`include "host_command_deframer_macros.svh"

module hcd_datapath
    import hcd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    input  wire logic [7:0]           packet_byte,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output logic [RID_W-1:0]          robot_id,
    output logic [SIZE_W-1:0]         payload_size,
    output logic [SIZE_W-1:0]         byte_index,
    output logic [7:0]                data_byte,
    output logic                      has_data,
    output logic                      frame_end,
    output logic                      run_end
);

    logic [7:0] mem [PACKET_BYTES];
    logic [7:0] rdata_reg;

    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [SIZE_W-1:0] idx_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [RID_W-1:0]  rid_reg;
    logic              rid_ok_reg;
    logic              type_match_reg;
    logic [RC_W-1:0]   robot_count_reg;
    logic [7:0]        vel_type_reg;

    logic [CNT_W-1:0]  rem;
    logic [CNT_W-1:0]  addr_full;
    logic [RC_W-1:0]   limit;
    logic              out_free;
    logic              emit;

    // Staged result waiting to learn whether it is the last one of the packet
    logic              pend_valid_reg, pend_valid_next;
    logic [RID_W-1:0]  pend_rid_reg;
    logic [SIZE_W-1:0] pend_size_reg;
    logic [SIZE_W-1:0] pend_idx_reg;
    logic [7:0]        pend_data_reg;
    logic              pend_has_reg;
    logic              pend_fend_reg;

    logic              out_valid_reg, out_valid_next;
    logic              out_load;
    logic [RID_W-1:0]  out_rid_reg;
    logic [SIZE_W-1:0] out_size_reg;
    logic [SIZE_W-1:0] out_idx_reg;
    logic [7:0]        out_data_reg;
    logic              out_has_reg;
    logic              out_fend_reg;
    logic              out_rend_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            robot_count_reg <= '0;
            vel_type_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ROBOT_COUNT:   robot_count_reg <= cfg_data[RC_W-1:0];
                CFG_VELOCITY_TYPE: vel_type_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign limit = (robot_count_reg < RC_W'(MAX_ROBOTS)) ? robot_count_reg
                                                          : RC_W'(MAX_ROBOTS);

    // Select the store read address
    always_comb
    begin
        case (cmd.rd_sel)
            RD_HEAD:      addr_full = pos_reg;
            RD_TYPE:      addr_full = pos_reg + CNT_W'(1);
            RD_RID:       addr_full = pos_reg + CNT_W'(2);
            RD_SIZE:      addr_full = pos_reg + CNT_W'(3);
            RD_STOP:      addr_full = pos_reg + CNT_W'(4) + CNT_W'(rdata_reg);
            RD_DATA:      addr_full = pos_reg + CNT_W'(4) + CNT_W'(idx_reg);
            RD_DATA_NEXT: addr_full = pos_reg + CNT_W'(5) + CNT_W'(idx_reg);
            default:      addr_full = pos_reg;
        endcase
    end

    // Write accepted bytes while the store has room, read one byte per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (fill_reg < CNT_W'(PACKET_BYTES)))
        begin
            mem[fill_reg[ADDR_W-1:0]] <= packet_byte;
        end
        rdata_reg <= mem[addr_full[ADDR_W-1:0]];
    end

    // Advance fill count and scan cursor
    always_comb
    begin
        fill_next = fill_reg;
        pos_next  = pos_reg;
        if (cmd.accept && (fill_reg < CNT_W'(PACKET_BYTES)))
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        if (cmd.clear_fill)
        begin
            fill_next = '0;
            pos_next  = '0;
        end
        else if (cmd.pos_inc)
        begin
            pos_next = pos_reg + CNT_W'(1);
        end
        else if (cmd.pos_skip)
        begin
            pos_next = pos_reg + CNT_W'(size_reg) + CNT_W'(FRAME_OVERHEAD);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
        end
    end

    // Capture frame header fields
    always_ff @(posedge clk)
    begin
        if (cmd.cap_type)
        begin
            type_match_reg <= (rdata_reg == vel_type_reg);
        end
        if (cmd.cap_rid)
        begin
            rid_reg    <= rdata_reg[RID_W-1:0];
            rid_ok_reg <= (9'(rdata_reg) < 9'(limit));
        end
        if (cmd.cap_size)
        begin
            size_reg <= rdata_reg[SIZE_W-1:0];
            idx_reg  <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + SIZE_W'(1);
        end
    end

    assign rem      = fill_reg - pos_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = cmd.emit_note || cmd.emit_data;

    // Report status to the sequencer
    always_comb
    begin
        status.short_tail = (rem < CNT_W'(FRAME_OVERHEAD));
        status.head_ok    = (rdata_reg == START_MARK);
        status.overrun    = ((9'(rdata_reg) + 9'(FRAME_OVERHEAD)) > 9'(rem));
        status.frame_ok   = rid_ok_reg && (rdata_reg == STOP_MARK);
        status.data_frame = type_match_reg && (size_reg != '0);
        status.last_data  = ((7'(idx_reg) + 7'd1) == 7'(size_reg));
        status.emit_ok    = !pend_valid_reg || out_free;
        status.flush_ok   = !pend_valid_reg || out_free;
    end

    // Move the staged result to the output register and stage new ones
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_load        = 1'b0;
        if (emit)
        begin
            out_load        = pend_valid_reg;
            pend_valid_next = 1'b1;
        end
        else if (cmd.flush && pend_valid_reg && out_free)
        begin
            out_load        = 1'b1;
            pend_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_rid_reg  <= pend_rid_reg;
            out_size_reg <= pend_size_reg;
            out_idx_reg  <= pend_idx_reg;
            out_data_reg <= pend_data_reg;
            out_has_reg  <= pend_has_reg;
            out_fend_reg <= pend_fend_reg;
            out_rend_reg <= !emit;
        end
        if (emit)
        begin
            pend_rid_reg  <= rid_reg;
            pend_size_reg <= size_reg;
            pend_idx_reg  <= cmd.emit_data ? idx_reg : '0;
            pend_data_reg <= cmd.emit_data ? rdata_reg : 8'd0;
            pend_has_reg  <= cmd.emit_data;
            pend_fend_reg <= cmd.emit_note || status.last_data;
        end
    end

    assign out_valid    = out_valid_reg;
    assign robot_id     = out_rid_reg;
    assign payload_size = out_size_reg;
    assign byte_index   = out_idx_reg;
    assign data_byte    = out_data_reg;
    assign has_data     = out_has_reg;
    assign frame_end    = out_fend_reg;
    assign run_end      = out_rend_reg;

    `HCD_ASSERT_IMP(a_emit_room, emit && pend_valid_reg, out_free, "result staged with no room")
    `HCD_ASSERT_IMP(a_pos_in_fill, 1'b1, pos_reg <= fill_reg, "scan cursor past fill count")
    `HCD_ASSERT_IMP(a_idx_in_size, cmd.emit_data, idx_reg < size_reg, "payload index past size")
    `HCD_ASSERT_NXT(a_flush_clears, cmd.clear_fill, !pend_valid_reg && (fill_reg == '0),
                    "scan ended with a staged result")

endmodule

`default_nettype wire

/* sv/host_command_deframer.sv */
// Top level of the host command deframer: sequencer plus datapath.
// Depends on hcd_pkg, hcd_ctrl and hcd_datapath.
//
//  Channel  Handshake             Payload
//  -------  --------------------  ------------------------------------------------
//  input    in_valid / in_stall   packet_byte, packet_end
//  output   out_valid / out_stall robot_id, payload_size, byte_index, data_byte,
//                                 has_data, frame_end, run_end
//  config   cfg_valid / cfg_ready cfg_index, cfg_data
//
//  Loading accepts a byte whenever in_valid is high; in_stall is low only while loading.
//  After the final byte the scan reads the packet store one byte per cycle: at
//  each position it checks for a start mark, then reads the type, robot id, size and
//  stop mark, then emits a notice or one result per payload byte, and at the end flushes.
//  Each result is held one stage until the next one or the end of the scan,
//  so run_end can mark the last; a stalled output pauses the scan.
//  rst_n clears the control state; the packet store is not cleared.
`default_nettype none

module host_command_deframer
    import hcd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           packet_byte,
    input  wire logic                 packet_end,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [RID_W-1:0]          robot_id,
    output logic [SIZE_W-1:0]         payload_size,
    output logic [SIZE_W-1:0]         byte_index,
    output logic [7:0]                data_byte,
    output logic                      has_data,
    output logic                      frame_end,
    output logic                      run_end,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data
);

    cmd_t    cmd;
    status_t status;

    // Configuration writes are always accepted
    assign cfg_ready = 1'b1;

    hcd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .packet_end (packet_end),
        .status     (status),
        .cmd        (cmd),
        .in_stall   (in_stall)
    );

    hcd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .packet_byte  (packet_byte),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .robot_id     (robot_id),
        .payload_size (payload_size),
        .byte_index   (byte_index),
        .data_byte    (data_byte),
        .has_data     (has_data),
        .frame_end    (frame_end),
        .run_end      (run_end)
    );

endmodule

`default_nettype wire
